// ===== design/dpd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the delayed phase difference block: widths, the CORDIC
// working state type and the elementary angle table. No dependencies.
package dpd_pkg;

  // Sample and phase widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 16;

  // Products of two samples and their sums.
  localparam int unsigned PROD_W = 2 * SAMPLE_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // The vector is scaled by 2^20 before the iterations. The extra two bits
  // hold the CORDIC gain and the growth of the vector length.
  localparam int unsigned PRESCALE_SH = 20;
  localparam int unsigned VEC_W       = SUM_W + PRESCALE_SH + 2;

  // Angle accumulator: modulo 2^32, with 2^31 standing for pi.
  localparam int unsigned ANGLE_W = 32;
  localparam logic [ANGLE_W-1:0] ANGLE_PI    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_ROUND = 32'h0000_8000;

  // Number of vectoring iterations.
  localparam int unsigned STEPS = 31;

  // One complex sample.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } sample_t;

  // Working state passed from cell to cell.
  typedef struct packed {
    logic                     zero;
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic [ANGLE_W-1:0]       acc;
  } cordic_t;

  // atan(2^-k) in accumulator units.
  function automatic logic [ANGLE_W-1:0] atan_angle(input logic [4:0] k);
    logic [ANGLE_W-1:0] a;
    case (k)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      5'd24:   a = 32'd41;
      5'd25:   a = 32'd20;
      5'd26:   a = 32'd10;
      5'd27:   a = 32'd5;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      5'd30:   a = 32'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/dpd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample items and phase items.
// Depends on dpd_pkg for the field widths.
interface dpd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dpd_pkg::SAMPLE_W-1:0] sample_i;
  logic signed [dpd_pkg::SAMPLE_W-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface dpd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpd_pkg::PHASE_W-1:0] phase;

  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface

// ===== design/delayed_phase_difference.sv =====
`timescale 1ns / 1ps
// Top level of the delayed phase difference discriminator.
// Depends on dpd_pkg, dpd_if, dpd_front and dpd_cordic_cell.
//
//   channel   direction   payload                    handshake
//   in_ch     sink        sample_i, sample_q (s16)   valid / ready
//   out_ch    source      phase (s16, -32768 = pi)   valid / ready
//
// One item is accepted per cycle while out_ch does not stall; each item
// passes multiply, combine, 31 CORDIC cells and the rounding register.
// Each pipeline cell holds one item.
// Reset clears every stage valid bit and the sample delay line to zero.
// A stall on out_ch holds the output item; earlier stages keep filling
// their empty slots, and in_ch.ready drops only when the chain is full.
module delayed_phase_difference #(
  parameter int unsigned LAG = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  dpd_in_if.sink     in_ch,
  dpd_out_if.source  out_ch
);

  localparam int unsigned STEPS = dpd_pkg::STEPS;

  dpd_pkg::cordic_t chain_st  [STEPS+1];
  logic             chain_v   [STEPS+1];
  logic             chain_rdy [STEPS+1];

  logic                               out_valid_r;
  logic signed [dpd_pkg::PHASE_W-1:0] phase_r;
  logic signed [dpd_pkg::PHASE_W-1:0] phase_nxt;
  logic [dpd_pkg::ANGLE_W-1:0]        rounded;
  logic                               fin_ready;

  // Delay line, products and fold.
  dpd_front #(
    .LAG (LAG)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_sample_i (in_ch.sample_i),
    .in_sample_q (in_ch.sample_q),
    .out_valid   (chain_v[0]),
    .out_ready   (chain_rdy[0]),
    .out_st      (chain_st[0])
  );

  // Row of CORDIC cells, one per iteration.
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    dpd_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[k]),
      .in_ready  (chain_rdy[k]),
      .in_st     (chain_st[k]),
      .out_valid (chain_v[k+1]),
      .out_ready (chain_rdy[k+1]),
      .out_st    (chain_st[k+1])
    );
  end

  // Round the accumulated angle to 16 bits; a zero product gives zero.
  always_comb begin
    rounded = chain_st[STEPS].acc + dpd_pkg::ANGLE_ROUND;
    if (chain_st[STEPS].zero) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = rounded[dpd_pkg::ANGLE_W-1 -: dpd_pkg::PHASE_W];
    end
  end

  // Output register.
  assign fin_ready        = !out_valid_r || out_ch.ready;
  assign chain_rdy[STEPS] = fin_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= chain_v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && chain_v[STEPS]) begin
      phase_r <= phase_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.phase = phase_r;

  // A zero product stays a zero vector through every cell.
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (chain_v[STEPS] && chain_st[STEPS].zero) |->
      ((chain_st[STEPS].x == '0) && (chain_st[STEPS].y == '0)))
    else $error("zero item reached the output as a non-zero vector");

  // A result taken by the output register is held until it is delivered.
  a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(phase_r)))
    else $error("stalled output item changed");

  // With the output register free, the last cell always drains.
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> chain_rdy[STEPS])
    else $error("last cell blocked by an empty output register");

endmodule

// ===== design/dpd_front.sv =====
`timescale 1ns / 1ps
// Front end: sample delay line, conjugate multiply and half-plane fold.
// Depends on dpd_pkg. Feeds the first CORDIC cell.
module dpd_front #(
  parameter int unsigned LAG = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dpd_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic signed [dpd_pkg::SAMPLE_W-1:0] in_sample_q,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dpd_pkg::cordic_t                    out_st
);

  localparam int unsigned PW = dpd_pkg::PROD_W;
  localparam int unsigned SW = dpd_pkg::SUM_W;
  localparam int unsigned VW = dpd_pkg::VEC_W;

  dpd_pkg::sample_t line_r [LAG];
  dpd_pkg::sample_t old_s;
  logic             in_fire;

  logic                 p_valid_r;
  logic                 p_ready;
  logic signed [PW-1:0] ac_r, bd_r, bc_r, ad_r;

  logic                 s_valid_r;
  dpd_pkg::cordic_t     s_r;
  dpd_pkg::cordic_t     s_nxt;
  logic signed [SW-1:0] re_s, im_s;
  logic signed [VW-1:0] x_pre, y_pre;

  // The sample from LAG items ago sits at the far end of the line.
  assign old_s   = line_r[LAG-1];
  assign in_fire = in_valid && in_ready;

  // Delay line: shifts once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < LAG; n++) begin
        line_r[n] <= '0;
      end
    end else if (in_fire) begin
      line_r[0] <= '{i: in_sample_i, q: in_sample_q};
      for (int n = 1; n < LAG; n++) begin
        line_r[n] <= line_r[n-1];
      end
    end
  end

  // Multiply stage: the four cross products of old and new.
  assign in_ready = !p_valid_r || p_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_ready) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ac_r <= old_s.i * in_sample_i;
      bd_r <= old_s.q * in_sample_q;
      bc_r <= old_s.q * in_sample_i;
      ad_r <= old_s.i * in_sample_q;
    end
  end

  // Combine stage: real and imaginary parts, prescale and fold into the
  // right half plane.
  assign p_ready = !s_valid_r || out_ready;

  always_comb begin
    re_s  = SW'(ac_r) + SW'(bd_r);
    im_s  = SW'(bc_r) - SW'(ad_r);
    x_pre = VW'(re_s) <<< dpd_pkg::PRESCALE_SH;
    y_pre = VW'(im_s) <<< dpd_pkg::PRESCALE_SH;
    s_nxt.zero = (re_s == '0) && (im_s == '0);
    if (re_s[SW-1]) begin
      s_nxt.x   = -x_pre;
      s_nxt.y   = -y_pre;
      s_nxt.acc = dpd_pkg::ANGLE_PI;
    end else begin
      s_nxt.x   = x_pre;
      s_nxt.y   = y_pre;
      s_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (p_ready) begin
      s_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && p_valid_r) begin
      s_r <= s_nxt;
    end
  end

  assign out_valid = s_valid_r;
  assign out_st    = s_r;

  // An empty multiply stage always takes an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !p_valid_r |-> in_ready)
    else $error("front end refused an item with an empty multiply stage");

  // After the fold the real part is never negative.
  a_fold_right_half: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> !s_r.x[VW-1])
    else $error("folded vector lies in the left half plane");

  // A zero product is carried as a zero vector with zero angle.
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_r.zero) |-> ((s_r.x == '0) && (s_r.y == '0) && (s_r.acc == '0)))
    else $error("zero flag set on a non-zero vector");

endmodule

// ===== design/dpd_cordic_cell.sv =====
`timescale 1ns / 1ps
// One vectoring CORDIC cell with its own pipeline register and handshake.
// Depends on dpd_pkg.
module dpd_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dpd_pkg::cordic_t in_st,
  output logic             out_valid,
  input  logic             out_ready,
  output dpd_pkg::cordic_t out_st
);

  localparam logic [dpd_pkg::ANGLE_W-1:0] ANGLE = dpd_pkg::atan_angle(5'(SHIFT));

  logic                             valid_r;
  dpd_pkg::cordic_t                 st_r;
  dpd_pkg::cordic_t                 st_nxt;
  logic signed [dpd_pkg::VEC_W-1:0] dx, dy;
  logic                             y_pos;

  // One micro-rotation towards the positive real axis.
  always_comb begin
    dx     = $signed(in_st.y) >>> SHIFT;
    dy     = $signed(in_st.x) >>> SHIFT;
    y_pos  = !in_st.y[dpd_pkg::VEC_W-1] && (in_st.y != '0);
    st_nxt = in_st;
    if (y_pos) begin
      st_nxt.x   = in_st.x + dx;
      st_nxt.y   = in_st.y - dy;
      st_nxt.acc = in_st.acc + ANGLE;
    end else begin
      st_nxt.x   = in_st.x - dx;
      st_nxt.y   = in_st.y + dy;
      st_nxt.acc = in_st.acc - ANGLE;
    end
  end

  // Stage register: advances when empty or when the next cell takes the item.
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for delayed_phase_difference: random valid/ready traffic
// on both channels, with a CORDIC phase predictor built into the bench.
// Depends on dpd_pkg, dpd_if and the design sources.
module testbench;

  localparam int unsigned LAG_ITEMS   = 3;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dpd_in_if  in_bus ();
  dpd_out_if out_bus ();

  delayed_phase_difference #(
    .LAG (LAG_ITEMS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Elementary angles atan(2^-k), 2^31 standing for pi.
  logic [dpd_pkg::ANGLE_W-1:0] atan_units [0:dpd_pkg::STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  dpd_pkg::sample_t             pending_samples [$];
  logic [dpd_pkg::PHASE_W-1:0]  expected_phases [$];
  dpd_pkg::sample_t             sample_history [0:LAG_ITEMS-1];
  int unsigned           mismatches = 0;
  int unsigned           items_sent = 0;
  int unsigned           cycle_no = 0;
  int unsigned           send_gap = 0;
  int unsigned           stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Angle of old * conj(new) by 31 vectoring steps, rounded to 16 bits.
  function automatic logic [dpd_pkg::PHASE_W-1:0] lagged_phase(
      input dpd_pkg::sample_t old_s, input dpd_pkg::sample_t new_s);
    longint a, b, c, d, re, im, x, y, dx, dy;
    logic [dpd_pkg::ANGLE_W-1:0] acc;
    logic [dpd_pkg::ANGLE_W-1:0] rounded;
    int k;
    a = old_s.i;
    b = old_s.q;
    c = new_s.i;
    d = new_s.q;
    re = a * c + b * d;
    im = b * c - a * d;
    // A zero product has no angle; the block reports zero.
    if (re == 0 && im == 0) return '0;
    x = re <<< dpd_pkg::PRESCALE_SH;
    y = im <<< dpd_pkg::PRESCALE_SH;
    acc = '0;
    // Fold the left half-plane onto the right one, starting the angle at pi.
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = dpd_pkg::ANGLE_PI;
    end
    for (k = 0; k < dpd_pkg::STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + atan_units[k];
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - atan_units[k];
      end
    end
    rounded = acc + dpd_pkg::ANGLE_ROUND;
    return rounded[dpd_pkg::ANGLE_W-1:dpd_pkg::ANGLE_W-dpd_pkg::PHASE_W];
  endfunction

  // Idle length after an item: mostly none or short, now and then long.
  // Every fourth window of 64 items is sent back to back.
  function automatic int unsigned next_send_gap(input int unsigned sent);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (((sent >> 6) % 4) == 1) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic dpd_pkg::sample_t make_sample(input int si, input int sq);
    dpd_pkg::sample_t s;
    s.i = si[dpd_pkg::SAMPLE_W-1:0];
    s.q = sq[dpd_pkg::SAMPLE_W-1:0];
    return s;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  // Sample source: presents queued items, records each accepted item and
  // predicts its phase from the item LAG_ITEMS places earlier.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      for (int n = 0; n < LAG_ITEMS; n++) sample_history[n] = '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_phases.push_back(lagged_phase(sample_history[LAG_ITEMS-1],
                                               make_sample(in_bus.sample_i,
                                                           in_bus.sample_q)));
        for (int n = LAG_ITEMS - 1; n > 0; n--) sample_history[n] = sample_history[n-1];
        sample_history[0] = make_sample(in_bus.sample_i, in_bus.sample_q);
        items_sent <= items_sent + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_bus.valid    <= 1'b1;
          in_bus.sample_i <= pending_samples[0].i;
          in_bus.sample_q <= pending_samples[0].q;
          void'(pending_samples.pop_front());
          send_gap <= next_send_gap(items_sent);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Phase sink: random back-pressure and comparison with the oldest
  // expected phase.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_phases.size() == 0) begin
          $display("%0t: phase item with nothing expected, got %0d",
                   $time, out_bus.phase);
          mismatches <= mismatches + 1;
        end else begin
          if (out_bus.phase !== expected_phases[0]) begin
            $display("%0t: phase mismatch, expected %0d, got %0d", $time,
                     $signed(expected_phases[0]), out_bus.phase);
            mismatches <= mismatches + 1;
          end
          void'(expected_phases.pop_front());
        end
      end
      // In every fourth window of the cycle count the sink starts no new stall.
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if (((cycle_no >> 7) % 4) != 2 && $urandom_range(0, 99) < 20) begin
        out_bus.ready <= 1'b0;
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                 : $urandom_range(10, 60);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int unsigned pick;
    int unsigned run_len;
    int unsigned j;
    int si, sq, rot;
    real amp, theta, step;

    in_bus.valid    = 1'b0;
    in_bus.sample_i = '0;
    in_bus.sample_q = '0;
    out_bus.ready   = 1'b0;

    // Directed items: full-scale values, zero products while the delay line
    // is still empty, the negative real axis (angle of pi) and small vectors.
    pending_samples.push_back(make_sample(32767, 0));
    pending_samples.push_back(make_sample(0, 0));
    pending_samples.push_back(make_sample(-32768, -32768));
    pending_samples.push_back(make_sample(-32767, 0));
    pending_samples.push_back(make_sample(0, 0));
    pending_samples.push_back(make_sample(-32768, -32768));
    pending_samples.push_back(make_sample(32767, 32767));
    pending_samples.push_back(make_sample(0, -32768));
    pending_samples.push_back(make_sample(-32768, 32767));
    pending_samples.push_back(make_sample(1, 0));
    pending_samples.push_back(make_sample(0, 1));
    pending_samples.push_back(make_sample(-1, -1));
    pending_samples.push_back(make_sample(-1, 0));
    pending_samples.push_back(make_sample(0, -1));
    pending_samples.push_back(make_sample(32767, -32768));
    pending_samples.push_back(make_sample(-32768, 0));
    pending_samples.push_back(make_sample(0, 32767));
    pending_samples.push_back(make_sample(1, 1));
    pending_samples.push_back(make_sample(32767, 32767));
    pending_samples.push_back(make_sample(-32768, -32768));

    // Random items: constant-envelope tones and quarter-turn sequences make
    // up much of the stream, with full-range noise and corner values mixed in.
    while (pending_samples.size() < 20 + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        pending_samples.push_back(make_sample($urandom_range(0, 65535),
                                              $urandom_range(0, 65535)));
      end else if (pick < 50) begin
        run_len = $urandom_range(6, 24);
        amp = $urandom_range(1000, 32767);
        theta = $urandom_range(0, 6283) / 1000.0;
        step = ($urandom_range(0, 2000) - 1000.0) / 1000.0 * 3.14159;
        for (j = 0; j < run_len; j++) begin
          pending_samples.push_back(make_sample($rtoi(amp * $cos(theta)),
                                                $rtoi(amp * $sin(theta))));
          theta = theta + step;
        end
      end else if (pick < 60) begin
        run_len = $urandom_range(6, 16);
        si = $urandom_range(0, 65534) - 32767;
        sq = $urandom_range(0, 65534) - 32767;
        rot = $urandom_range(0, 3);
        for (j = 0; j < run_len; j++) begin
          pending_samples.push_back(make_sample(si, sq));
          // Rotate by rot quarter turns; the range excludes -32768.
          repeat (rot) begin
            pick = si;
            si = -sq;
            sq = pick;
          end
        end
      end else if (pick < 75) begin
        pending_samples.push_back(make_sample($urandom_range(0, 8) - 4,
                                              $urandom_range(0, 8) - 4));
      end else if (pick < 88) begin
        pending_samples.push_back(make_sample(corner_value(), corner_value()));
      end else if (pick < 94) begin
        pending_samples.push_back(make_sample($urandom_range(0, 65535), 0));
      end else begin
        pending_samples.push_back(make_sample(0, $urandom_range(0, 65535)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every phase to come back.
    @(negedge clk);
    while (pending_samples.size() > 0 || in_bus.valid || expected_phases.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== delayed_phase_difference.f =====
design/dpd_pkg.sv
design/dpd_if.sv
design/dpd_front.sv
design/dpd_cordic_cell.sv
design/delayed_phase_difference.sv
bench/testbench.sv
